// ===== src/svia_pkg.sv =====
`default_nettype none
package svia_pkg;

    localparam int unsigned DataW = 32;

    typedef enum logic [2:0] {
        ACT_ADD = 3'd0,
        ACT_SUB = 3'd1,
        ACT_MUL = 3'd2,
        ACT_DIV = 3'd3,
        ACT_REM = 3'd4
    } t_action;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_BAD  = 2'd1,
        ST_DIV0 = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        SZ_8  = 2'd0,
        SZ_16 = 2'd1,
        SZ_32 = 2'd2
    } t_size;

    typedef enum logic [1:0] {
        K_ARITH = 2'd0,
        K_DIV   = 2'd1,
        K_FIXED = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic              is_rem;
        logic              sub;
        logic              mul;
        t_size             size;
        logic              neg_q;
        logic              neg_r;
        logic              div_ovf;
        logic [1:0]        status;
        logic [DataW-1:0]  a;
        logic [DataW-1:0]  b;
    } t_op;

    function automatic logic [DataW-1:0] size_mask(input t_size sz);
        logic [DataW-1:0] m;
        begin
            case (sz)
                SZ_8:    m = 32'h0000_00FF;
                SZ_16:   m = 32'h0000_FFFF;
                default: m = 32'hFFFF_FFFF;
            endcase
            return m;
        end
    endfunction

endpackage
`default_nettype wire

// ===== src/svia_front.sv =====
`default_nettype none
module svia_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_load,
    input  wire logic [2:0]        i_action,
    input  wire logic              i_is_signed,
    input  wire logic [7:0]        i_operand_bytes,
    input  wire logic [31:0]       i_operand_a,
    input  wire logic [31:0]       i_operand_b,
    output logic                   o_valid,
    output svia_pkg::t_op          o_op
);

    svia_pkg::t_op n_op;
    svia_pkg::t_op r_op;
    logic          r_valid;
    logic [31:0]   w_mask;
    logic [31:0]   w_a;
    logic [31:0]   w_b;
    logic          w_sa;
    logic          w_sb;
    logic          w_size_ok;
    svia_pkg::t_size w_size;
    logic [31:0]   w_min;

    always_comb begin
        w_size_ok = 1'b1;
        case (i_operand_bytes)
            8'd1:    w_size = svia_pkg::SZ_8;
            8'd2:    w_size = svia_pkg::SZ_16;
            8'd4:    w_size = svia_pkg::SZ_32;
            default: begin
                w_size = svia_pkg::SZ_32;
                w_size_ok = 1'b0;
            end
        endcase
        w_mask = svia_pkg::size_mask(w_size);
        w_a = i_operand_a & w_mask;
        w_b = i_operand_b & w_mask;
        case (w_size)
            svia_pkg::SZ_8: begin
                w_sa = i_is_signed & w_a[7];
                w_sb = i_is_signed & w_b[7];
                w_min = 32'h0000_0080;
            end
            svia_pkg::SZ_16: begin
                w_sa = i_is_signed & w_a[15];
                w_sb = i_is_signed & w_b[15];
                w_min = 32'h0000_8000;
            end
            default: begin
                w_sa = i_is_signed & w_a[31];
                w_sb = i_is_signed & w_b[31];
                w_min = 32'h8000_0000;
            end
        endcase

        n_op         = '0;
        n_op.size    = w_size;
        n_op.sub     = (i_action == svia_pkg::ACT_SUB);
        n_op.mul     = (i_action == svia_pkg::ACT_MUL);
        n_op.is_rem  = (i_action == svia_pkg::ACT_REM);
        n_op.neg_q   = w_sa ^ w_sb;
        n_op.neg_r   = w_sa;
        n_op.div_ovf = i_is_signed && (w_a == w_min) && (w_b == w_mask);
        n_op.a       = w_sa ? ((~w_a + 32'd1) & w_mask) : w_a;
        n_op.b       = w_sb ? ((~w_b + 32'd1) & w_mask) : w_b;
        n_op.status  = svia_pkg::ST_OK;
        n_op.kind    = svia_pkg::K_ARITH;
        if (!w_size_ok || i_action > svia_pkg::ACT_REM) begin
            n_op.kind   = svia_pkg::K_FIXED;
            n_op.status = svia_pkg::ST_BAD;
        end else if (i_action == svia_pkg::ACT_DIV || i_action == svia_pkg::ACT_REM) begin
            if (w_b == '0) begin
                n_op.kind   = svia_pkg::K_FIXED;
                n_op.status = svia_pkg::ST_DIV0;
            end else begin
                n_op.kind = svia_pkg::K_DIV;
            end
        end else begin
            n_op.a = w_a;
            n_op.b = w_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_load;
        end
        if (i_load) begin
            r_op <= n_op;
        end
    end

    assign o_valid = r_valid;
    assign o_op    = r_op;

endmodule
`default_nettype wire

// ===== src/svia_back.sv =====
`default_nettype none
module svia_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire svia_pkg::t_op     i_op,
    output logic                   o_valid,
    output logic [31:0]            o_result,
    output logic [1:0]             o_status
);

    localparam int unsigned Stages = 32;

    logic          r_v   [Stages+1];
    svia_pkg::t_op r_op  [Stages+1];
    logic [31:0]   r_q   [Stages+1];
    logic [31:0]   r_rem [Stages+1];
    logic [31:0]   r_res;
    logic [1:0]    r_st;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
        end
        r_op[0]  <= i_op;
        r_q[0]   <= i_op.a;
        r_rem[0] <= '0;
        case (i_op.kind)
            svia_pkg::K_ARITH: begin
                if (i_op.mul) begin
                    r_res <= 32'(i_op.a * i_op.b) & svia_pkg::size_mask(i_op.size);
                end else if (i_op.sub) begin
                    r_res <= (i_op.a - i_op.b) & svia_pkg::size_mask(i_op.size);
                end else begin
                    r_res <= (i_op.a + i_op.b) & svia_pkg::size_mask(i_op.size);
                end
            end
            default: r_res <= '0;
        endcase
        r_st <= i_op.status;
    end

    genvar g;
    generate
        for (g = 0; g < Stages; g++) begin : g_div
            logic [32:0] w_t;
            logic [31:0] w_r;
            logic [31:0] w_qn;
            logic        w_sub;
            assign w_r   = {r_rem[g][30:0], r_q[g][31-g]};
            assign w_t   = {1'b0, w_r} - {1'b0, r_op[g].b};
            assign w_sub = !w_t[32] || r_rem[g][31];
            always_comb begin
                w_qn        = r_q[g];
                w_qn[31-g]  = w_sub;
            end
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[g+1] <= 1'b0;
                end else begin
                    r_v[g+1] <= r_v[g];
                end
                r_op[g+1]  <= r_op[g];
                r_q[g+1]   <= w_qn;
                r_rem[g+1] <= w_sub ? w_t[31:0] : w_r;
            end
        end
    endgenerate

    logic [Stages:0] r_fast_v;
    logic [31:0]     r_fast_res [1:Stages];
    logic [1:0]      r_fast_st  [1:Stages];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fast_v <= '0;
        end else begin
            r_fast_v <= {r_fast_v[Stages-1:0], i_valid};
        end
        r_fast_res[1] <= r_res;
        r_fast_st[1]  <= r_st;
        for (int k = 2; k <= Stages; k++) begin
            r_fast_res[k] <= r_fast_res[k-1];
            r_fast_st[k]  <= r_fast_st[k-1];
        end
    end

    logic [31:0] w_q;
    logic [31:0] w_r2;
    logic [31:0] w_m;
    svia_pkg::t_op w_op;

    always_comb begin
        w_op = r_op[Stages];
        w_m  = svia_pkg::size_mask(w_op.size);
        w_q  = w_op.neg_q ? (~r_q[Stages] + 32'd1) : r_q[Stages];
        w_r2 = w_op.neg_r ? (~r_rem[Stages] + 32'd1) : r_rem[Stages];
        if (w_op.kind == svia_pkg::K_DIV) begin
            o_status = svia_pkg::ST_OK;
            if (w_op.is_rem) begin
                o_result = w_op.div_ovf ? '0 : (w_r2 & w_m);
            end else begin
                o_result = w_q & w_m;
            end
        end else begin
            o_result = r_fast_res[Stages];
            o_status = r_fast_st[Stages];
        end
    end

    assign o_valid = r_v[Stages] & r_fast_v[Stages];

endmodule
`default_nettype wire

// ===== src/stack_vm_integer_alu_top.sv =====
`default_nettype none
// Channel   Signals                                          Direction
// command   start, busy (out), i_action .. i_operand_b      in
// result    o_done, o_result, o_status                      out
// Each transaction passes the front and input registers and the 32-stage
// restoring divider; other results ride an equal-length delay line in order.
// A new transaction is taken every cycle; busy stays low outside reset.
// Reset is synchronous; it clears the valid bits of every stage.
// The receiver cannot stall: o_done is high for one cycle per result.
module stack_vm_integer_alu_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  i_action,
    input  wire logic        i_is_signed,
    input  wire logic [7:0]  i_operand_bytes,
    input  wire logic [31:0] i_operand_a,
    input  wire logic [31:0] i_operand_b,
    output logic             o_done,
    output logic [31:0]      o_result,
    output logic [1:0]       o_status
);

    logic          w_fv;
    svia_pkg::t_op w_op;

    assign busy = ~i_rst_n;

    svia_front u_front (
        .i_clk, .i_rst_n,
        .i_load          (start & ~busy),
        .i_action, .i_is_signed, .i_operand_bytes, .i_operand_a, .i_operand_b,
        .o_valid         (w_fv),
        .o_op            (w_op)
    );

    svia_back u_back (
        .i_clk, .i_rst_n,
        .i_valid  (w_fv),
        .i_op     (w_op),
        .o_valid  (o_done),
        .o_result,
        .o_status
    );

endmodule
`default_nettype wire

// ===== src/svia_checker.sv =====
`default_nettype none
module svia_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        o_done,
    input wire logic [1:0]  o_status,
    input wire logic [31:0] o_result
);
    a_st: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> o_status != 2'd3) else $error("bad status");
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status != svia_pkg::ST_OK) |-> o_result == '0)
        else $error("nonzero on error");
    a_busy: assert property (@(posedge i_clk)
        i_rst_n |-> !busy) else $error("busy");
endmodule

bind stack_vm_integer_alu_top svia_checker u_chk (.*);
`default_nettype wire
